// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HFW_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`define HFW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hfw_pkg.sv =====
// ----------------------------------------------------------------------------
// hfw_pkg
// Shared types and constants of the homography forward warp.
// ----------------------------------------------------------------------------
`default_nettype none

package hfw_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int MID_DEPTH   = 8;

    localparam int PROD_W  = 45;
    localparam int SUM_W   = 47;
    localparam int MAG_W   = 46;
    localparam int MAGN_W  = 52;
    localparam int CMP_W   = 64;
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;

    localparam logic [2:0] CFG_LIN0   = 3'd0;
    localparam logic [2:0] CFG_LIN1   = 3'd1;
    localparam logic [2:0] CFG_TRANS  = 3'd2;
    localparam logic [2:0] CFG_PERSP  = 3'd3;
    localparam logic [2:0] CFG_SCALE  = 3'd4;
    localparam logic [2:0] CFG_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_HEIGHT = 3'd6;

    localparam logic [63:0] RST_LIN0  = 64'h0100_0000_0000_0000;
    localparam logic [63:0] RST_LIN1  = 64'h0000_0000_0100_0000;
    localparam logic [63:0] RST_TRANS = 64'h0;
    localparam logic [63:0] RST_PERSP = 64'h0;
    localparam logic [31:0] RST_SCALE = 32'h0100_0000;
    localparam logic [SIZE_W-1:0] RST_SIZE = 13'd4096;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h02;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
        logic signed [31:0] h12;
        logic signed [31:0] h20;
        logic signed [31:0] h21;
        logic signed [31:0] h22;
    } t_coef;

    typedef struct packed {
        logic [MAGN_W-1:0] mag_nx;
        logic [MAGN_W-1:0] mag_ny;
        logic [MAG_W-1:0]  mag_w;
        logic              ok;
        t_pixel            pix;
    } t_mid_item;

    typedef struct packed {
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic               valid;
        t_pixel             pix;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/homography_forward_warp.sv =====
// ----------------------------------------------------------------------------
// homography_forward_warp
// Maps each source pixel through a configured 3x3 homography and emits the
// destination coordinate, the pixel and a write-valid flag.
// ----------------------------------------------------------------------------
// One pixel is taken per clock cycle while full is low, and one result leaves
// per cycle while pop is high and the result queue is not empty. A pixel passes
// 3 front stages, the middle queue and log2(MAX_DIM) + 1 divider stages before
// it reaches the result queue; the divider makes one quotient bit per stage.
// Coefficients may only be written while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module homography_forward_warp #(
    parameter int MAX_DIM = hfw_pkg::MAX_DIM_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire [11:0]  i_src_x,
    input  wire [11:0]  i_src_y,
    input  wire [7:0]   i_pixel_blue,
    input  wire [7:0]   i_pixel_green,
    input  wire [7:0]   i_pixel_red,
    output logic        empty,
    input  wire         pop,
    output logic [11:0] o_dst_x,
    output logic [11:0] o_dst_y,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    output logic        o_write_valid,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [5:0]   paddr,
    input  wire [63:0]  pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int QW        = $clog2(MAX_DIM);
    localparam int OUT_DEPTH = 2 ** $clog2(QW + 3);

    logic [63:0]                     r_lin0, r_lin1, r_trans, r_persp;
    logic [31:0]                     r_scale;
    logic [hfw_pkg::SIZE_W-1:0]      r_width, r_height;
    logic                            cfg_we;

    hfw_pkg::t_coef                  coef;
    hfw_pkg::t_pixel                 in_pix;
    logic                            mid_push, mid_pop, mid_empty, mid_full;
    hfw_pkg::t_mid_item              mid_in, mid_out;
    logic                            out_push, out_full, out_empty;
    hfw_pkg::t_out_item              out_in, out_head;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin0   <= hfw_pkg::RST_LIN0;
            r_lin1   <= hfw_pkg::RST_LIN1;
            r_trans  <= hfw_pkg::RST_TRANS;
            r_persp  <= hfw_pkg::RST_PERSP;
            r_scale  <= hfw_pkg::RST_SCALE;
            r_width  <= hfw_pkg::RST_SIZE;
            r_height <= hfw_pkg::RST_SIZE;
        end else if (cfg_we) begin
            case (paddr[5:3])
                hfw_pkg::CFG_LIN0:   r_lin0   <= pwdata;
                hfw_pkg::CFG_LIN1:   r_lin1   <= pwdata;
                hfw_pkg::CFG_TRANS:  r_trans  <= pwdata;
                hfw_pkg::CFG_PERSP:  r_persp  <= pwdata;
                hfw_pkg::CFG_SCALE:  r_scale  <= pwdata[31:0];
                hfw_pkg::CFG_WIDTH:  r_width  <= pwdata[hfw_pkg::SIZE_W-1:0];
                hfw_pkg::CFG_HEIGHT: r_height <= pwdata[hfw_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            hfw_pkg::CFG_LIN0:   prdata = r_lin0;
            hfw_pkg::CFG_LIN1:   prdata = r_lin1;
            hfw_pkg::CFG_TRANS:  prdata = r_trans;
            hfw_pkg::CFG_PERSP:  prdata = r_persp;
            hfw_pkg::CFG_SCALE:  prdata = 64'(r_scale);
            hfw_pkg::CFG_WIDTH:  prdata = 64'(r_width);
            hfw_pkg::CFG_HEIGHT: prdata = 64'(r_height);
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        coef.h00 = signed'(r_lin0[63:32]);
        coef.h01 = signed'(r_lin0[31:0]);
        coef.h10 = signed'(r_lin1[63:32]);
        coef.h11 = signed'(r_lin1[31:0]);
        coef.h02 = signed'(r_trans[63:32]);
        coef.h12 = signed'(r_trans[31:0]);
        coef.h20 = signed'(r_persp[63:32]);
        coef.h21 = signed'(r_persp[31:0]);
        coef.h22 = signed'(r_scale);
        in_pix.blue  = i_pixel_blue;
        in_pix.green = i_pixel_green;
        in_pix.red   = i_pixel_red;
    end

    hfw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coef       (coef),
        .i_push       (push),
        .o_full       (full),
        .i_x          (i_src_x),
        .i_y          (i_src_y),
        .i_pix        (in_pix),
        .i_credit_ret (mid_pop),
        .o_mid_push   (mid_push),
        .o_mid_item   (mid_in)
    );

    hfw_fifo #(
        .DEPTH  (hfw_pkg::MID_DEPTH),
        .t_item (hfw_pkg::t_mid_item)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_full  (mid_full),
        .o_data  (mid_out)
    );

    hfw_back #(
        .MAX_DIM   (MAX_DIM),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mid_empty  (mid_empty),
        .i_mid_item   (mid_out),
        .o_mid_pop    (mid_pop),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_credit_ret (pop && !empty),
        .o_out_push   (out_push),
        .o_out_item   (out_in)
    );

    hfw_fifo #(
        .DEPTH  (OUT_DEPTH),
        .t_item (hfw_pkg::t_out_item)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_empty (out_empty),
        .o_full  (out_full),
        .o_data  (out_head)
    );

    assign empty         = out_empty;
    assign o_dst_x       = out_head.dst_x;
    assign o_dst_y       = out_head.dst_y;
    assign o_out_blue    = out_head.pix.blue;
    assign o_out_green   = out_head.pix.green;
    assign o_out_red     = out_head.pix.red;
    assign o_write_valid = out_head.valid;

    `HFW_ASSERT_NEVER(a_mid_overflow, mid_push && mid_full, "Middle queue overflow.")
    `HFW_ASSERT_NEVER(a_out_overflow, out_push && out_full, "Result queue overflow.")
    `HFW_ASSERT_IMPLY(a_invalid_zero, !empty && !o_write_valid, (o_dst_x == '0) && (o_dst_y == '0), "Invalid word carries a nonzero coordinate.")

endmodule

`default_nettype wire

// ===== rtl/hfw_fifo.sv =====
// ----------------------------------------------------------------------------
// hfw_fifo
// Small first-in first-out queue of register entries.
// ----------------------------------------------------------------------------
`default_nettype none

module hfw_fifo #(
    parameter int DEPTH = hfw_pkg::MID_DEPTH,
    parameter type t_item = hfw_pkg::t_mid_item
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_data,
    input  wire   i_pop,
    output logic  o_empty,
    output logic  o_full,
    output t_item o_data
);

    localparam int AW = $clog2(DEPTH);

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;
    logic [AW:0]      n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hfw_front.sv =====
// ----------------------------------------------------------------------------
// hfw_front
// Accepts pixels, forms the projected numerators and divisor, and classifies
// signs into magnitudes for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module hfw_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  hfw_pkg::t_coef                  i_coef,
    input  wire                             i_push,
    output logic                            o_full,
    input  wire [hfw_pkg::COORD_W-1:0]      i_x,
    input  wire [hfw_pkg::COORD_W-1:0]      i_y,
    input  hfw_pkg::t_pixel                 i_pix,
    input  wire                             i_credit_ret,
    output logic                            o_mid_push,
    output hfw_pkg::t_mid_item              o_mid_item
);

    localparam int PW = hfw_pkg::PROD_W;
    localparam int SW = hfw_pkg::SUM_W;
    localparam int MW = hfw_pkg::MAG_W;
    localparam int CW = $clog2(hfw_pkg::MID_DEPTH + 1);

    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           n_cnt;
    logic                    accept;
    logic signed [12:0]      xs;
    logic signed [12:0]      ys;

    logic                    r_v1;
    logic signed [PW-1:0]    r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    hfw_pkg::t_pixel         r_pix1;

    logic                    r_v2;
    logic signed [SW-1:0]    r_nx, r_ny, r_w;
    hfw_pkg::t_pixel         r_pix2;

    logic                    r_v3;
    hfw_pkg::t_mid_item      r_item3;

    logic signed [SW-1:0]    abs_nx, abs_ny, abs_w;
    logic                    w_pos, w_neg, ok_x, ok_y;
    hfw_pkg::t_mid_item      n_item3;

    assign o_full = (r_cnt == CW'(hfw_pkg::MID_DEPTH));
    assign accept = i_push && !o_full;
    assign xs     = signed'({1'b0, i_x});
    assign ys     = signed'({1'b0, i_y});

    always_comb begin
        n_cnt = r_cnt + CW'(accept) - CW'(i_credit_ret);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_v1  <= accept;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p00  <= PW'(i_coef.h00) * PW'(xs);
        r_p01  <= PW'(i_coef.h01) * PW'(ys);
        r_p10  <= PW'(i_coef.h10) * PW'(xs);
        r_p11  <= PW'(i_coef.h11) * PW'(ys);
        r_p20  <= PW'(i_coef.h20) * PW'(xs);
        r_p21  <= PW'(i_coef.h21) * PW'(ys);
        r_pix1 <= i_pix;
    end

    always_ff @(posedge i_clk) begin
        r_nx   <= SW'(r_p00) + SW'(r_p01) + (SW'(i_coef.h02) <<< 8);
        r_ny   <= SW'(r_p10) + SW'(r_p11) + (SW'(i_coef.h12) <<< 8);
        r_w    <= SW'(r_p20) + SW'(r_p21) + (SW'(i_coef.h22) <<< 6);
        r_pix2 <= r_pix1;
    end

    always_comb begin
        abs_nx = r_nx[SW-1] ? -r_nx : r_nx;
        abs_ny = r_ny[SW-1] ? -r_ny : r_ny;
        abs_w  = r_w[SW-1] ? -r_w : r_w;
        w_pos  = !r_w[SW-1] && (r_w != '0);
        w_neg  = r_w[SW-1];
        ok_x   = (w_pos && !r_nx[SW-1]) || (w_neg && (r_nx[SW-1] || r_nx == '0));
        ok_y   = (w_pos && !r_ny[SW-1]) || (w_neg && (r_ny[SW-1] || r_ny == '0));
        n_item3.mag_nx = {abs_nx[MW-1:0], 6'b0};
        n_item3.mag_ny = {abs_ny[MW-1:0], 6'b0};
        n_item3.mag_w  = abs_w[MW-1:0];
        n_item3.ok     = ok_x && ok_y;
        n_item3.pix    = r_pix2;
    end

    always_ff @(posedge i_clk) begin
        r_item3 <= n_item3;
    end

    assign o_mid_push = r_v3;
    assign o_mid_item = r_item3;

endmodule

`default_nettype wire

// ===== rtl/hfw_back.sv =====
// ----------------------------------------------------------------------------
// hfw_back
// Pipelined restoring divider, one quotient bit per stage, followed by the
// image bounds check.
// ----------------------------------------------------------------------------
`default_nettype none

module hfw_back #(
    parameter int MAX_DIM   = hfw_pkg::MAX_DIM_DEF,
    parameter int OUT_DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_mid_empty,
    input  hfw_pkg::t_mid_item          i_mid_item,
    output logic                        o_mid_pop,
    input  wire [hfw_pkg::SIZE_W-1:0]   i_width,
    input  wire [hfw_pkg::SIZE_W-1:0]   i_height,
    input  wire                         i_credit_ret,
    output logic                        o_out_push,
    output hfw_pkg::t_out_item          o_out_item
);

    localparam int QW  = $clog2(MAX_DIM);
    localparam int CW  = $clog2(OUT_DEPTH + 1);
    localparam int NW  = hfw_pkg::MAGN_W;
    localparam int MW  = hfw_pkg::MAG_W;
    localparam int XW  = hfw_pkg::CMP_W;
    localparam int LW  = 17;

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;

    logic               r_v   [QW+1];
    logic [NW-1:0]      r_rx  [QW+1];
    logic [NW-1:0]      r_ry  [QW+1];
    logic [MW-1:0]      r_w   [QW+1];
    logic               r_ok  [QW+1];
    hfw_pkg::t_pixel    r_pix [QW+1];
    logic [QW-1:0]      r_qx  [QW+1];
    logic [QW-1:0]      r_qy  [QW+1];

    logic [XW-1:0]      wsh;
    logic               ok0;
    logic [LW-1:0]      lim_w, lim_h;
    logic               valid;

    assign o_mid_pop = !i_mid_empty && (r_cnt != CW'(OUT_DEPTH));

    always_comb begin
        n_cnt = r_cnt + CW'(o_mid_pop) - CW'(i_credit_ret);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        wsh = XW'(i_mid_item.mag_w) << QW;
        ok0 = i_mid_item.ok && (XW'(i_mid_item.mag_nx) < wsh)
              && (XW'(i_mid_item.mag_ny) < wsh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= o_mid_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx[0]  <= i_mid_item.mag_nx;
        r_ry[0]  <= i_mid_item.mag_ny;
        r_w[0]   <= i_mid_item.mag_w;
        r_ok[0]  <= ok0;
        r_pix[0] <= i_mid_item.pix;
        r_qx[0]  <= '0;
        r_qy[0]  <= '0;
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [XW-1:0] t;
        logic          gx;
        logic          gy;

        always_comb begin
            t  = XW'(r_w[k-1]) << (QW - k);
            gx = XW'(r_rx[k-1]) >= t;
            gy = XW'(r_ry[k-1]) >= t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rx[k]  <= gx ? NW'(XW'(r_rx[k-1]) - t) : r_rx[k-1];
            r_ry[k]  <= gy ? NW'(XW'(r_ry[k-1]) - t) : r_ry[k-1];
            r_w[k]   <= r_w[k-1];
            r_ok[k]  <= r_ok[k-1];
            r_pix[k] <= r_pix[k-1];
            r_qx[k]  <= {r_qx[k-1][QW-2:0], gx};
            r_qy[k]  <= {r_qy[k-1][QW-2:0], gy};
        end
    end

    always_comb begin
        lim_w = (LW'(i_width) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(i_width);
        lim_h = (LW'(i_height) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(i_height);
        valid = r_ok[QW] && (LW'(r_qx[QW]) < lim_w) && (LW'(r_qy[QW]) < lim_h);
        o_out_item.dst_x = valid ? hfw_pkg::COORD_W'(r_qx[QW]) : '0;
        o_out_item.dst_y = valid ? hfw_pkg::COORD_W'(r_qy[QW]) : '0;
        o_out_item.valid = valid;
        o_out_item.pix   = r_pix[QW];
    end

    assign o_out_push = r_v[QW];

endmodule

`default_nettype wire
